@@ sv/lcdns_pkg.sv @@
`timescale 1ns / 1ps
// Package for the character-LCD nibble sequencer: payload and job types,
// LCD command constants and the step-table functions. No dependencies.
package lcdns_pkg;

   // Payload of the request and response channels
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] value;
      logic [5:0] column;
      logic [1:0] row;
   } req_type;

   localparam int unsigned WAIT_W = 15;

   typedef struct packed {
      logic              reg_select;
      logic [3:0]        nibble;
      logic              strobe_res;
      logic [WAIT_W-1:0] wait_us;
      logic              last;
   } rsp_type;

   // Request kinds
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_CHAR   = 3'd1;
   localparam logic [2:0] CMD_BYTE   = 3'd2;
   localparam logic [2:0] CMD_SETPOS = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ROW_TOP    = 2'd0;
   localparam logic [1:0] ROW_BOTTOM = 2'd1;

   // Register port
   localparam int unsigned CSR_AW = 2;
   localparam int unsigned CSR_DW = 32;
   localparam logic [CSR_AW-1:0] CSR_ADDR_NEWLINE = 2'd0;

   // LCD bytes and nibbles
   localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
   localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
   localparam logic [7:0] LCD_CLEAR      = 8'h01;
   localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] LCD_HOME_ADDR  = 8'h80;
   localparam logic [7:0] LCD_DISP_ON    = 8'h0E;
   localparam logic [6:0] LCD_ROW1_BASE  = 7'h40;
   localparam logic [7:0] LCD_NL_ADDR    = 8'hC0;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

   // Extra wait after the last nibble of a byte
   localparam int unsigned EXTRA_W = 11;
   localparam logic [EXTRA_W-1:0] EXTRA_NONE  = 11'd0;
   localparam logic [EXTRA_W-1:0] EXTRA_POS   = 11'd40;
   localparam logic [EXTRA_W-1:0] EXTRA_CMD   = 11'd100;
   localparam logic [EXTRA_W-1:0] EXTRA_CLEAR = 11'd2000;

   localparam logic [WAIT_W-1:0] WAIT_ROW_SKIP = 15'd40;

   // Init sequence shape
   localparam int unsigned INIT_PRE_STEPS = 5;
   localparam int unsigned INIT_BYTES     = 6;

   // Byte phases
   localparam logic [1:0] PH_SETUP = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      JOB_INIT = 2'd0,
      JOB_BYTE = 2'd1,
      JOB_WAIT = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic               rs;
      logic [7:0]         data;
      logic [EXTRA_W-1:0] extra;
   } job_type;

   // One step of a byte transfer
   function automatic rsp_type byte_step(logic rs, logic [7:0] data,
                                         logic [EXTRA_W-1:0] extra, logic [1:0] phase);
      rsp_type           s;
      logic [WAIT_W-1:0] gap;
      gap          = rs ? WAIT_W'(30) : WAIT_W'(100);
      s.reg_select = rs;
      s.last       = 1'b0;
      case (phase)
         PH_SETUP: begin
            s.nibble     = 4'h0;
            s.strobe_res = 1'b0;
            s.wait_us    = rs ? WAIT_W'(5) : WAIT_W'(10);
         end
         PH_HIGH: begin
            s.nibble     = data[7:4];
            s.strobe_res = 1'b1;
            s.wait_us    = gap;
         end
         default: begin
            s.nibble     = data[3:0];
            s.strobe_res = 1'b1;
            s.wait_us    = gap + WAIT_W'(extra);
         end
      endcase
      return s;
   endfunction

   // Power-up wake steps ahead of the init command bytes
   function automatic rsp_type pre_step(logic [2:0] idx);
      rsp_type s;
      s.reg_select = 1'b0;
      s.last       = 1'b0;
      s.strobe_res = 1'b1;
      case (idx)
         3'd0: begin
            s.nibble     = 4'h0;
            s.strobe_res = 1'b0;
            s.wait_us    = WAIT_W'(30000);
         end
         3'd1: begin
            s.nibble  = NIB_WAKE;
            s.wait_us = WAIT_W'(6000);
         end
         3'd2: begin
            s.nibble  = NIB_WAKE;
            s.wait_us = WAIT_W'(150);
         end
         3'd3: begin
            s.nibble  = NIB_WAKE;
            s.wait_us = WAIT_W'(100);
         end
         default: begin
            s.nibble  = NIB_FOUR_BIT;
            s.wait_us = WAIT_W'(100);
         end
      endcase
      return s;
   endfunction

   function automatic logic [7:0] init_byte(logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0:    b = LCD_FUNC_SET;
         3'd1:    b = LCD_DISP_OFF;
         3'd2:    b = LCD_CLEAR;
         3'd3:    b = LCD_ENTRY_MODE;
         3'd4:    b = LCD_HOME_ADDR;
         default: b = LCD_DISP_ON;
      endcase
      return b;
   endfunction

   function automatic logic [EXTRA_W-1:0] init_extra(logic [2:0] k);
      return (k == 3'd2) ? EXTRA_CLEAR : EXTRA_CMD;
   endfunction

endpackage

@@ sv/lcdns_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them into jobs, holds the
// newline register and its APB-style port. Uses lcdns_pkg.
module lcdns_front import lcdns_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job
);

   logic newline_ff;
   logic newline_in;
   logic known;

   assign req_ready  = ~q_full;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_NEWLINE) ? CSR_DW'(newline_ff) : '0;

   always_comb begin
      newline_in = newline_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_ADDR_NEWLINE)) begin
         newline_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newline_ff <= 1'b1;
      end else begin
         newline_ff <= newline_in;
      end
   end

   // Classify
   always_comb begin
      known       = 1'b1;
      q_job.kind  = JOB_BYTE;
      q_job.rs    = 1'b0;
      q_job.data  = req_data.value;
      q_job.extra = EXTRA_NONE;
      unique case (req_data.cmd)
         CMD_INIT: begin
            q_job.kind = JOB_INIT;
         end
         CMD_CHAR: begin
            if (req_data.value == CHAR_NEWLINE && newline_ff) begin
               q_job.data  = LCD_NL_ADDR;
               q_job.extra = EXTRA_POS;
            end else begin
               q_job.rs = 1'b1;
            end
         end
         CMD_BYTE: begin
         end
         CMD_SETPOS: begin
            q_job.extra = EXTRA_POS;
            case (req_data.row)
               ROW_TOP:    q_job.data = {2'b10, req_data.column};
               ROW_BOTTOM: q_job.data = {1'b1, 7'(LCD_ROW1_BASE + {1'b0, req_data.column})};
               default:    q_job.kind = JOB_WAIT;
            endcase
         end
         CMD_CLEAR: begin
            q_job.data  = LCD_CLEAR;
            q_job.extra = EXTRA_CLEAR;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Drop unknown kinds: accept them but queue nothing
   assign q_push = req_valid & req_ready & known;

endmodule

@@ sv/lcdns_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Uses lcdns_pkg for the job type and depth.
module lcdns_queue import lcdns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/lcdns_back.sv @@
`timescale 1ns / 1ps
// Back end: step sequencer that expands jobs into timed bus steps and
// drives the response register. Uses lcdns_pkg.
module lcdns_back import lcdns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  job_type q_job,
   input  logic    q_empty,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PRE  = 4'b0010,
      ST_BYTE = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] pre_ff, pre_in;
   logic [2:0] init_k_ff, init_k_in;
   logic       init_mode_ff, init_mode_in;
   logic       rs_level_ff, rs_level_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       slot_free;
   logic       more_init;
   rsp_type    step;

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign more_init = init_mode_ff & (init_k_ff != 3'(INIT_BYTES - 1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      phase_in     = phase_ff;
      pre_in       = pre_ff;
      init_k_in    = init_k_ff;
      init_mode_in = init_mode_ff;
      rs_level_in  = rs_level_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      step         = byte_step(job_ff.rs, job_ff.data, job_ff.extra, phase_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               job_in    = q_job;
               phase_in  = PH_SETUP;
               init_k_in = '0;
               pre_in    = '0;
               case (q_job.kind)
                  JOB_INIT: begin
                     state_in     = ST_PRE;
                     init_mode_in = 1'b1;
                  end
                  JOB_BYTE: begin
                     state_in     = ST_BYTE;
                     init_mode_in = 1'b0;
                  end
                  default: begin
                     state_in     = ST_WAIT;
                     init_mode_in = 1'b0;
                  end
               endcase
            end
         end
         ST_PRE: begin
            if (slot_free) begin
               rsp_in       = pre_step(pre_ff);
               rsp_valid_in = 1'b1;
               rs_level_in  = 1'b0;
               if (pre_ff == 3'(INIT_PRE_STEPS - 1)) begin
                  state_in     = ST_BYTE;
                  job_in.rs    = 1'b0;
                  job_in.data  = init_byte('0);
                  job_in.extra = init_extra('0);
               end else begin
                  pre_in = pre_ff + 1'b1;
               end
            end
         end
         ST_BYTE: begin
            if (slot_free) begin
               step.last    = (phase_ff == PH_LOW) & ~more_init;
               rsp_in       = step;
               rsp_valid_in = 1'b1;
               rs_level_in  = job_ff.rs;
               if (phase_ff == PH_LOW) begin
                  phase_in = PH_SETUP;
                  if (more_init) begin
                     // chain to the next init command byte
                     init_k_in    = init_k_ff + 1'b1;
                     job_in.data  = init_byte(init_k_ff + 1'b1);
                     job_in.extra = init_extra(init_k_ff + 1'b1);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               rsp_in.reg_select = rs_level_ff;
               rsp_in.nibble     = 4'h0;
               rsp_in.strobe_res = 1'b0;
               rsp_in.wait_us    = WAIT_ROW_SKIP;
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SETUP;
         pre_ff       <= '0;
         init_k_ff    <= '0;
         init_mode_ff <= 1'b0;
         rs_level_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pre_ff       <= pre_in;
         init_k_ff    <= init_k_in;
         init_mode_ff <= init_mode_in;
         rs_level_ff  <= rs_level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ sv/char_lcd_nibble_sequencer_top.sv @@
`timescale 1ns / 1ps
// Character-LCD 4-bit bus sequencer, top level. Depends on lcdns_pkg,
// lcdns_front, lcdns_queue and lcdns_back.
// A request's job passes the queue and the back end's job register; its steps then show on rsp
// from the response register. Throughput: one step per cycle once running, while rsp_ready
// keeps the output free; each request's job is first fetched from the queue in the idle state.
// The back-end step sequencer sets that rate; the front stops accepting while two jobs wait.
// Reset (synchronous): newline register to 1, RS level to instruction, queue and output empty.
module char_lcd_nibble_sequencer_top import lcdns_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   // step channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // Job handoff between front and back
   logic    q_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   job_type push_job;
   job_type head_job;

   // Classify requests; unknown kinds are taken and dropped here
   lcdns_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   // Hold jobs so the front waits on a slow display sequence only when the queue is full
   lcdns_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Expand each job into its bus steps and drive the registered output
   lcdns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_job     (head_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/lcdns_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the LCD nibble sequencer, bound to the top level.
// Uses lcdns_pkg for the payload types.
module lcdns_checker import lcdns_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsp_type           rsp_data,
   input logic              csr_pready
);

   // Stalled step holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled step changed");

   // Output is empty right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("step valid after reset");

   // Wait-only steps carry a zero nibble
   a_idle_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.strobe_res |-> rsp_data.nibble == 4'h0)
      else $error("nibble on a step without strobe");

   // Strobed data-register nibbles use only data timing
   a_data_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_select && rsp_data.strobe_res |->
         rsp_data.wait_us == WAIT_W'(30))
      else $error("bad wait on data nibble");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind char_lcd_nibble_sequencer_top lcdns_checker u_lcdns_checker (.*);
